[design/wav_stream_downmixer_defines.svh]
// assertion macros used by the checker
`ifndef WAV_STREAM_DOWNMIXER_DEFINES_SVH
`define WAV_STREAM_DOWNMIXER_DEFINES_SVH

// condition implies property in the same cycle
`define WSD_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("port check failed");

// condition implies property in the next cycle
`define WSD_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("port check failed");

`endif

[design/wsd_pkg.sv]
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_SEARCH = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    RT_PASS  = 3'd0,
    RT_LEFT  = 3'd1,
    RT_RIGHT = 3'd2,
    RT_MIX8  = 3'd3,
    RT_MIX16 = 3'd4
  } route_t;

  typedef enum logic [1:0] {
    MIX_LEFT    = 2'd0,
    MIX_RIGHT   = 2'd1,
    MIX_AVERAGE = 2'd2,
    MIX_STEREO  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RK_HEADER = 2'd0,
    RK_SAMPLE = 2'd1,
    RK_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_RIFF        = 4'd0,
    ERR_WAVE_FMT    = 4'd1,
    ERR_CHUNK_SIZE  = 4'd2,
    ERR_FORMAT      = 4'd3,
    ERR_CHANNELS    = 4'd4,
    ERR_NO_DATA     = 4'd5,
    ERR_MONO_STEREO = 4'd6,
    ERR_SHORT       = 4'd7,
    ERR_WIDTH       = 4'd8
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  sample_byte;
    logic [31:0] format_word;
    logic [31:0] output_length;
    err_t        error_code;
    logic        final_result;
  } result_t;

  // second result of an item: a sample byte or an error only
  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] sample_byte;
    err_t       error_code;
    logic       final_result;
  } tail_t;

  typedef struct packed {
    logic    two;
    result_t first;
    tail_t   second;
  } entry_t;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_ADDR_W = $clog2(QUEUE_DEPTH);

  localparam int BITS_W = 16;
  localparam int WID_W  = BITS_W - 3;
  localparam int POS_W  = WID_W + 1;
  localparam int GAP_W  = POS_W + 1;
  localparam int RATE_W = 30;

  localparam int OFS_RIFF         = 3;
  localparam int OFS_WAVE         = 11;
  localparam int OFS_FMT          = 15;
  localparam int OFS_SIZE         = 19;
  localparam int OFS_FORMAT       = 21;
  localparam int OFS_CHANNELS     = 23;
  localparam int OFS_RATE         = 27;
  localparam int OFS_BITS         = 35;
  localparam int OFS_SEARCH_FIRST = 39;

  localparam logic [31:0] TAG_RIFF      = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE      = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT       = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA      = 32'h6461_7461;
  localparam logic [31:0] TAG_FMT_SIZE  = 32'h1000_0000;
  localparam logic [15:0] TAG_PCM       = 16'h0100;
  localparam logic [15:0] BITS_WIDE     = 16'd16;
  localparam int          FMT_WIDE_BIT  = 30;
  localparam int          FMT_STEREO_BIT = 31;

endpackage

[design/wav_stream_downmixer.sv]
// a result is written into the queue when its byte is accepted and then loaded into the output register
// throughput: one byte per cycle; the parser takes one byte each clock while the queue has room
// a 16-bit averaged frame gives its two result bytes one after the other from one queue entry, low byte first
// reset: synchronous rst returns the parser to the header, mode to 0, queue and output empty
module wav_stream_downmixer #(
  parameter int HEADER_WINDOW = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  wsd_pkg::item_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data
);

  logic            q_full;
  logic            push;
  wsd_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  wsd_pkg::entry_t head;

  wsd_front #(
    .HEADER_WINDOW(HEADER_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  wsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[design/wsd_front.sv]
module wsd_front #(
  parameter int HEADER_WINDOW = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  wsd_pkg::item_t   in_data,
  output logic             in_stall,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data,
  input  logic             q_full,
  output logic             push,
  output wsd_pkg::entry_t  push_entry
);

  localparam int OW = $clog2(HEADER_WINDOW) + 1;
  localparam int PW = wsd_pkg::POS_W;
  localparam int WW = wsd_pkg::WID_W;
  localparam int GW = wsd_pkg::GAP_W;
  localparam logic [OW-1:0] LAST_OFS = OW'(HEADER_WINDOW - 1);

  wsd_pkg::phase_t phase, phase_next;
  wsd_pkg::route_t route, route_new;
  wsd_pkg::mode_t  mode;
  logic [OW-1:0]   offset;
  logic [PW-1:0]   fpos;
  logic [31:0]     recent;
  logic [1:0]      chans;
  logic [wsd_pkg::RATE_W-1:0] rate;
  logic [wsd_pkg::BITS_W-1:0] bits;
  logic [31:0]     remaining;
  logic [15:0]     held_left;
  logic [7:0]      held_right;

  logic            accept;
  logic [7:0]      byte_in;
  logic            eof;
  logic [WW-1:0]   wid;
  logic [31:0]     rec_shift;
  logic [15:0]     ch_val;
  logic [31:0]     len_val;
  logic            search_hit;
  logic [2:0]      lpos;
  logic            len_hit;
  logic [31:0]     fmt;
  logic [31:0]     olen;
  logic            cfg_fail;
  wsd_pkg::err_t   cfg_code;
  logic            hdr_fin;
  logic [PW-1:0]   p1;
  logic [PW-1:0]   np;
  logic            emit;
  logic            data_fin;
  logic [7:0]      mix8;
  logic [15:0]     l_half;
  logic [15:0]     r_half;
  logic [15:0]     avg;
  logic [7:0]      sample0;
  logic            fail;
  wsd_pkg::err_t   fail_code;
  logic            two_err;

  // bytes up to and including the next one that gives a result
  function automatic logic [GW-1:0] gap_f(wsd_pkg::route_t rt, logic [PW-1:0] p,
                                          logic [WW-1:0] wd);
    logic [GW-1:0] g;
    unique case (rt)
      wsd_pkg::RT_LEFT: begin
        g = (p < {1'b0, wd}) ? GW'(1) : ({1'b0, wd, 1'b0} - {1'b0, p} + GW'(1));
      end
      wsd_pkg::RT_RIGHT: begin
        g = (p < {1'b0, wd}) ? ({2'b00, wd} - {1'b0, p} + GW'(1)) : GW'(1);
      end
      wsd_pkg::RT_MIX8:  g = (p == '0) ? GW'(2) : GW'(1);
      wsd_pkg::RT_MIX16: g = GW'(4) - {{(GW-2){1'b0}}, p[1:0]};
      default:           g = GW'(1);
    endcase
    return g;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign byte_in  = in_data.data_byte;
  assign eof      = in_data.end_of_file;
  assign wid      = bits[wsd_pkg::BITS_W-1:3];

  always_comb begin
    rec_shift  = {recent[23:0], byte_in};
    ch_val     = {rec_shift[7:0], rec_shift[15:8]};
    len_val    = {rec_shift[7:0], rec_shift[15:8], rec_shift[23:16], rec_shift[31:24]};
    search_hit = (offset >= OW'(wsd_pkg::OFS_SEARCH_FIRST)) &&
                 (rec_shift == wsd_pkg::TAG_DATA);
    lpos       = fpos[2:0] + 3'd1;
    len_hit    = (lpos == 3'd4);

    // header result and the route it fixes
    fmt       = {2'b00, rate};
    olen      = len_val;
    route_new = wsd_pkg::RT_PASS;
    cfg_fail  = 1'b0;
    cfg_code  = wsd_pkg::ERR_MONO_STEREO;
    if (bits == wsd_pkg::BITS_WIDE) fmt[wsd_pkg::FMT_WIDE_BIT] = 1'b1;
    if (chans == 2'd1) begin
      if (mode == wsd_pkg::MIX_STEREO) cfg_fail = 1'b1;
    end else if (mode == wsd_pkg::MIX_STEREO) begin
      fmt[wsd_pkg::FMT_STEREO_BIT] = 1'b1;
    end else begin
      if (wid == '0) begin
        cfg_fail = 1'b1;
        cfg_code = wsd_pkg::ERR_WIDTH;
      end
      olen = {1'b0, len_val[31:1]};
      unique case (mode)
        wsd_pkg::MIX_LEFT:  route_new = wsd_pkg::RT_LEFT;
        wsd_pkg::MIX_RIGHT: route_new = wsd_pkg::RT_RIGHT;
        default: route_new = (wid == WW'(1)) ? wsd_pkg::RT_MIX8 : wsd_pkg::RT_MIX16;
      endcase
    end
    hdr_fin = len_val < 32'(gap_f(route_new, '0, wid));

    // sample routing
    p1 = fpos + PW'(1);
    unique case (route)
      wsd_pkg::RT_LEFT: begin
        emit = fpos < {1'b0, wid};
        np   = (p1 >= {wid, 1'b0}) ? '0 : p1;
      end
      wsd_pkg::RT_RIGHT: begin
        emit = fpos >= {1'b0, wid};
        np   = (p1 >= {wid, 1'b0}) ? '0 : p1;
      end
      wsd_pkg::RT_MIX8: begin
        emit = fpos != '0;
        np   = (fpos == '0) ? PW'(1) : '0;
      end
      wsd_pkg::RT_MIX16: begin
        emit = fpos == PW'(3);
        np   = (fpos == PW'(3)) ? '0 : p1;
      end
      default: begin
        emit = 1'b1;
        np   = '0;
      end
    endcase
    data_fin = remaining <= 32'(gap_f(route, np, wid));

    mix8   = {1'b0, held_left[7:1]} + {1'b0, byte_in[7:1]};
    // halves truncated toward zero
    l_half = {held_left[15], held_left[15:1]} + {15'd0, held_left[15] & held_left[0]};
    r_half = {byte_in[7], byte_in[7:0], held_right[7:1]} + {15'd0, byte_in[7] & held_right[0]};
    avg    = l_half + r_half;
    unique case (route)
      wsd_pkg::RT_MIX8:  sample0 = mix8;
      wsd_pkg::RT_MIX16: sample0 = avg[7:0];
      default:           sample0 = byte_in;
    endcase

    fail      = 1'b0;
    fail_code = wsd_pkg::ERR_SHORT;
    two_err   = 1'b0;
    unique case (phase)
      wsd_pkg::PH_HEAD: begin
        if (offset == OW'(wsd_pkg::OFS_RIFF) && rec_shift != wsd_pkg::TAG_RIFF) begin
          fail      = 1'b1;
          fail_code = wsd_pkg::ERR_RIFF;
        end
        if (offset == OW'(wsd_pkg::OFS_WAVE) && rec_shift != wsd_pkg::TAG_WAVE) begin
          fail      = 1'b1;
          fail_code = wsd_pkg::ERR_WAVE_FMT;
        end
        if (offset == OW'(wsd_pkg::OFS_FMT) && rec_shift != wsd_pkg::TAG_FMT) begin
          fail      = 1'b1;
          fail_code = wsd_pkg::ERR_WAVE_FMT;
        end
        if (offset == OW'(wsd_pkg::OFS_SIZE) && rec_shift != wsd_pkg::TAG_FMT_SIZE) begin
          fail      = 1'b1;
          fail_code = wsd_pkg::ERR_CHUNK_SIZE;
        end
        if (offset == OW'(wsd_pkg::OFS_FORMAT) && rec_shift[15:0] != wsd_pkg::TAG_PCM) begin
          fail      = 1'b1;
          fail_code = wsd_pkg::ERR_FORMAT;
        end
        if (offset == OW'(wsd_pkg::OFS_CHANNELS) && ch_val != 16'd1 && ch_val != 16'd2) begin
          fail      = 1'b1;
          fail_code = wsd_pkg::ERR_CHANNELS;
        end
        if (!fail && eof) fail = 1'b1;
      end
      wsd_pkg::PH_SEARCH: begin
        if (!search_hit && offset >= LAST_OFS) begin
          fail      = 1'b1;
          fail_code = wsd_pkg::ERR_NO_DATA;
        end
        if (!fail && eof) fail = 1'b1;
      end
      wsd_pkg::PH_LENGTH: begin
        if (len_hit) begin
          if (cfg_fail) begin
            fail      = 1'b1;
            fail_code = cfg_code;
          end else begin
            two_err = eof && !hdr_fin;
          end
        end else if (eof) begin
          fail = 1'b1;
        end
      end
      wsd_pkg::PH_DATA: begin
        if (eof && remaining > 32'd1) fail = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (fail) begin
        phase_next = wsd_pkg::PH_DONE;
      end else begin
        unique case (phase)
          wsd_pkg::PH_HEAD: begin
            if (offset == OW'(wsd_pkg::OFS_BITS)) phase_next = wsd_pkg::PH_SEARCH;
          end
          wsd_pkg::PH_SEARCH: begin
            if (search_hit) phase_next = wsd_pkg::PH_LENGTH;
          end
          wsd_pkg::PH_LENGTH: begin
            if (len_hit) phase_next = (hdr_fin || eof) ? wsd_pkg::PH_DONE : wsd_pkg::PH_DATA;
          end
          wsd_pkg::PH_DATA: begin
            if (remaining == 32'd1) phase_next = wsd_pkg::PH_DONE;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    push_entry.second.result_kind  = wsd_pkg::RK_ERROR;
    push_entry.second.error_code   = wsd_pkg::ERR_SHORT;
    push_entry.second.final_result = 1'b1;
    if (accept) begin
      if (fail) begin
        push = 1'b1;
        push_entry.first.result_kind  = wsd_pkg::RK_ERROR;
        push_entry.first.error_code   = fail_code;
        push_entry.first.final_result = 1'b1;
      end else if (phase == wsd_pkg::PH_LENGTH && len_hit) begin
        push = 1'b1;
        push_entry.two                 = two_err;
        push_entry.first.result_kind   = wsd_pkg::RK_HEADER;
        push_entry.first.format_word   = fmt;
        push_entry.first.output_length = olen;
        push_entry.first.final_result  = hdr_fin;
      end else if (phase == wsd_pkg::PH_DATA && emit) begin
        push = 1'b1;
        push_entry.first.result_kind = wsd_pkg::RK_SAMPLE;
        push_entry.first.sample_byte = sample0;
        if (route == wsd_pkg::RT_MIX16) begin
          push_entry.two                 = 1'b1;
          push_entry.second.result_kind  = wsd_pkg::RK_SAMPLE;
          push_entry.second.sample_byte  = avg[15:8];
          push_entry.second.error_code   = wsd_pkg::ERR_RIFF;
          push_entry.second.final_result = data_fin;
        end else begin
          push_entry.first.final_result = data_fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= wsd_pkg::PH_HEAD;
      offset <= '0;
      fpos   <= '0;
      mode   <= wsd_pkg::MIX_LEFT;
      route  <= wsd_pkg::RT_PASS;
    end else begin
      phase <= phase_next;
      if (cfg_we) mode <= wsd_pkg::mode_t'(cfg_data);
      if (accept) begin
        unique case (phase)
          wsd_pkg::PH_HEAD: offset <= offset + OW'(1);
          wsd_pkg::PH_SEARCH: begin
            offset <= offset + OW'(1);
            if (search_hit) fpos <= '0;
          end
          wsd_pkg::PH_LENGTH: begin
            fpos <= len_hit ? '0 : PW'(lpos);
            if (len_hit) route <= route_new;
          end
          wsd_pkg::PH_DATA: fpos <= np;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (phase)
        wsd_pkg::PH_HEAD: begin
          recent <= rec_shift;
          if (offset == OW'(wsd_pkg::OFS_CHANNELS)) chans <= ch_val[1:0];
          if (offset == OW'(wsd_pkg::OFS_RATE)) rate <= len_val[wsd_pkg::RATE_W-1:0];
          if (offset == OW'(wsd_pkg::OFS_BITS)) bits <= ch_val;
        end
        wsd_pkg::PH_SEARCH: recent <= rec_shift;
        wsd_pkg::PH_LENGTH: begin
          recent <= rec_shift;
          if (len_hit) remaining <= len_val;
        end
        wsd_pkg::PH_DATA: begin
          remaining <= remaining - 32'd1;
          if ((route == wsd_pkg::RT_MIX8 || route == wsd_pkg::RT_MIX16) && fpos == '0) begin
            held_left <= {8'd0, byte_in};
          end
          if (route == wsd_pkg::RT_MIX16 && fpos == PW'(1)) held_left[15:8] <= byte_in;
          if (route == wsd_pkg::RT_MIX16 && fpos == PW'(2)) held_right <= byte_in;
        end
        default: ;
      endcase
    end
  end

endmodule

[design/wsd_queue.sv]
module wsd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsd_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output wsd_pkg::entry_t head
);

  localparam int QA = wsd_pkg::QUEUE_ADDR_W;

  wsd_pkg::entry_t slots [wsd_pkg::QUEUE_DEPTH];
  logic [QA-1:0]   wr_ptr;
  logic [QA-1:0]   rd_ptr;
  logic [QA:0]     count;

  assign full       = (count == (QA+1)'(wsd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QA'(1);
      if (pop) rd_ptr <= rd_ptr + QA'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QA+1)'(1);
        2'b01:   count <= count - (QA+1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

[design/wsd_back.sv]
module wsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  wsd_pkg::entry_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_data
);

  logic             sub;
  logic             load;
  wsd_pkg::result_t tail_res;

  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && (sub || !head.two);

  always_comb begin
    tail_res               = '0;
    tail_res.result_kind   = head.second.result_kind;
    tail_res.sample_byte   = head.second.sample_byte;
    tail_res.error_code    = head.second.error_code;
    tail_res.final_result  = head.second.final_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= head.two && !sub;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= sub ? tail_res : head.first;
  end

endmodule

[design/wsd_checker.sv]
`include "wav_stream_downmixer_defines.svh"

module wsd_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input wsd_pkg::result_t out_data
);

  `WSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_data))
  `WSD_ASSERT_IMPLY(a_error_final, out_valid && out_data.result_kind == wsd_pkg::RK_ERROR,
    out_data.final_result)
  `WSD_ASSERT_IMPLY(a_code_clear, out_valid && out_data.result_kind != wsd_pkg::RK_ERROR,
    out_data.error_code == wsd_pkg::ERR_RIFF)
  `WSD_ASSERT_IMPLY(a_sample_clean, out_valid && out_data.result_kind == wsd_pkg::RK_SAMPLE,
    out_data.format_word == 32'd0 && out_data.output_length == 32'd0)
  `WSD_ASSERT_NEXT(a_quiet_after_final, out_valid && !out_stall && out_data.final_result,
    !out_valid)

endmodule

bind wav_stream_downmixer wsd_checker u_checker (.*);
